FILE: hw/rtl/v4n_pkg.sv
// Shared widths and stage payload types for the vector normaliser.
package v4n_pkg;
  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int UNIT_WIDTH = FRAC_BITS + 2;
  localparam int MAG_WIDTH  = COMP_WIDTH + 1;
  localparam int ABS_WIDTH  = COMP_WIDTH;
  localparam int SUM_WIDTH  = 2 * COMP_WIDTH + 2;
  localparam int NUM_WIDTH  = ABS_WIDTH + FRAC_BITS;
  localparam int ROOT_STEPS = MAG_WIDTH;
  localparam int QUOT_BITS  = NUM_WIDTH + 1;
  localparam int REM_WIDTH  = MAG_WIDTH + 1;
  localparam logic [QUOT_BITS-1:0] UNIT_ONE = QUOT_BITS'(1) << FRAC_BITS;

  typedef logic [ABS_WIDTH-1:0] abs_t;
  typedef logic [MAG_WIDTH-1:0] mag_t;
  typedef logic [SUM_WIDTH-1:0] sum_t;
endpackage

FILE: hw/rtl/vector4_normalize.sv
// Top level of the four-component vector normaliser.
//
// Usage: a vector is offered on in_x..in_w with in_valid; a beat is taken at
// a rising edge where in_valid is high and in_stall is low. Results leave on
// unit_x..unit_w, magnitude and zero_vector with out_valid; the receiver
// holds off a beat by raising out_stall.
// The pipeline takes one vector per cycle when out_stall is low. Its stages
// are one for absolute values, one for squares, one for the sum, one per
// bit of the square root (17), one per quotient bit of the division (31,
// four dividers side by side) and a final rounding stage. The square root
// loop is unrolled into one register stage per trial step and the division
// loop into one per restoring step, which sets the depth.
// Reset clears every stage valid bit; the payload registers are left as they
// are. A receiver stall holds the output beat and backs up only through the
// stages that are full behind it, while bubbles keep filling, so in_stall
// rises only once all 52 stages hold beats and out_stall is high. Nothing is
// dropped or repeated.
// A zero vector still passes the division stages but sets no quotient bit:
// its unit fields are forced to zero, its magnitude is zero and zero_vector is raised.
module vector4_normalize
  import v4n_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] in_x,
  input  logic signed [COMP_WIDTH-1:0] in_y,
  input  logic signed [COMP_WIDTH-1:0] in_z,
  input  logic signed [COMP_WIDTH-1:0] in_w,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [UNIT_WIDTH-1:0] unit_x,
  output logic signed [UNIT_WIDTH-1:0] unit_y,
  output logic signed [UNIT_WIDTH-1:0] unit_z,
  output logic signed [UNIT_WIDTH-1:0] unit_w,
  output logic        [MAG_WIDTH-1:0]  magnitude,
  output logic                         zero_vector
);

  localparam int NSTG = 3 + ROOT_STEPS + QUOT_BITS + 1;
  localparam int RS0  = 3;
  localparam int DS0  = RS0 + ROOT_STEPS;
  localparam int LAST = NSTG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv[LAST] = !vld[LAST] || !out_stall;
    for (int s = LAST - 1; s >= 0; s--) begin
      adv[s] = !vld[s] || adv[s+1];
    end
  end
  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // Stage 0: absolute values and signs.
  abs_t a0 [4];
  logic n0 [4];
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a0[0] <= in_x[COMP_WIDTH-1] ? abs_t'(-in_x) : abs_t'(in_x);
      a0[1] <= in_y[COMP_WIDTH-1] ? abs_t'(-in_y) : abs_t'(in_y);
      a0[2] <= in_z[COMP_WIDTH-1] ? abs_t'(-in_z) : abs_t'(in_z);
      a0[3] <= in_w[COMP_WIDTH-1] ? abs_t'(-in_w) : abs_t'(in_w);
      n0[0] <= in_x[COMP_WIDTH-1];
      n0[1] <= in_y[COMP_WIDTH-1];
      n0[2] <= in_z[COMP_WIDTH-1];
      n0[3] <= in_w[COMP_WIDTH-1];
    end
  end

  // Stage 1: squares. Stage 2: sum.
  abs_t a1 [4];
  logic n1 [4];
  logic [2*ABS_WIDTH-1:0] sq1 [4];
  abs_t a2 [4];
  logic n2 [4];
  sum_t sum2;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 4; i++) begin
        a1[i]  <= a0[i];
        n1[i]  <= n0[i];
        sq1[i] <= a0[i] * a0[i];
      end
    end
    if (adv[2]) begin
      a2   <= a1;
      n2   <= n1;
      sum2 <= SUM_WIDTH'(sq1[0]) + SUM_WIDTH'(sq1[1])
            + SUM_WIDTH'(sq1[2]) + SUM_WIDTH'(sq1[3]);
    end
  end

  // Square root: one trial-square step per stage, most significant bit first.
  abs_t rt_a   [ROOT_STEPS+1][4];
  logic rt_n   [ROOT_STEPS+1][4];
  sum_t rt_rem [ROOT_STEPS+1];
  mag_t rt_q   [ROOT_STEPS+1];
  assign rt_a[0]   = a2;
  assign rt_n[0]   = n2;
  assign rt_rem[0] = sum2;
  assign rt_q[0]   = '0;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam int B = ROOT_STEPS - 1 - k;
    sum_t trial;
    mag_t qtry;
    always_comb begin
      qtry  = rt_q[k] | (mag_t'(1) << B);
      trial = sum_t'(qtry) * sum_t'(qtry);
    end
    // The trial square is compared against the original sum held in rt_rem.
    always_ff @(posedge clk) begin
      if (adv[RS0+k]) begin
        rt_a[k+1]   <= rt_a[k];
        rt_n[k+1]   <= rt_n[k];
        rt_rem[k+1] <= rt_rem[k];
        rt_q[k+1]   <= (trial <= rt_rem[k]) ? qtry : rt_q[k];
      end
    end
  end

  // Division: four restoring dividers in step, one quotient bit per stage.
  logic [NUM_WIDTH-1:0] dv_num [QUOT_BITS+1][4];
  logic [REM_WIDTH-1:0] dv_rem [QUOT_BITS+1][4];
  logic [QUOT_BITS-1:0] dv_q   [QUOT_BITS+1][4];
  logic                 dv_n   [QUOT_BITS+1][4];
  mag_t                 dv_m   [QUOT_BITS+1];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dv_num[0][i] = {rt_a[ROOT_STEPS][i], {FRAC_BITS{1'b0}}};
      dv_rem[0][i] = '0;
      dv_q[0][i]   = '0;
      dv_n[0][i]   = rt_n[ROOT_STEPS][i];
    end
    dv_m[0] = rt_q[ROOT_STEPS];
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    localparam int B = QUOT_BITS - 1 - k;
    logic [REM_WIDTH-1:0] sh [4];
    logic                 ge [4];
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        // The extra top quotient bit is always zero; it shifts nothing in.
        if (B < NUM_WIDTH) begin
          sh[i] = {dv_rem[k][i][REM_WIDTH-2:0], dv_num[k][i][B % NUM_WIDTH]};
        end else begin
          sh[i] = {dv_rem[k][i][REM_WIDTH-2:0], 1'b0};
        end
        ge[i] = (dv_m[k] != '0) && (sh[i] >= REM_WIDTH'(dv_m[k]));
      end
    end
    always_ff @(posedge clk) begin
      if (adv[DS0+k]) begin
        dv_m[k+1] <= dv_m[k];
        for (int i = 0; i < 4; i++) begin
          dv_num[k+1][i] <= dv_num[k][i];
          dv_n[k+1][i]   <= dv_n[k][i];
          dv_rem[k+1][i] <= ge[i] ? sh[i] - REM_WIDTH'(dv_m[k]) : sh[i];
          dv_q[k+1][i]   <= dv_q[k][i] | (ge[i] ? (QUOT_BITS'(1) << B) : '0);
        end
      end
    end
  end

  // Final stage: round half away from zero, saturate, apply sign.
  logic signed [UNIT_WIDTH-1:0] u_next [4];
  always_comb begin
    logic [QUOT_BITS-1:0] q;
    logic [REM_WIDTH:0]   r2;
    for (int i = 0; i < 4; i++) begin
      r2 = {dv_rem[QUOT_BITS][i], 1'b0};
      q  = dv_q[QUOT_BITS][i];
      if (r2 >= (REM_WIDTH+1)'(dv_m[QUOT_BITS])) q = q + QUOT_BITS'(1);
      if (q > UNIT_ONE) q = UNIT_ONE;
      if (dv_m[QUOT_BITS] == '0) q = '0;
      u_next[i] = dv_n[QUOT_BITS][i] ? -UNIT_WIDTH'(q) : UNIT_WIDTH'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      unit_x      <= u_next[0];
      unit_y      <= u_next[1];
      unit_z      <= u_next[2];
      unit_w      <= u_next[3];
      magnitude   <= dv_m[QUOT_BITS];
      zero_vector <= (dv_m[QUOT_BITS] == '0);
    end
  end
  assign out_valid = vld[LAST];

  // The magnitude and unit_x of a held result beat must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude) && $stable(unit_x))
    else $error("result changed under stall");
  // The zero flag and a zero length always come together.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_vector == (magnitude == '0)))
    else $error("zero flag disagrees with magnitude");
  // Input is only held off when the output is full and stalled.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
endmodule
